// ===== design/gcd_pkg.sv =====
package gcd_pkg;

  localparam int RED_W       = 31;  // signed angle in half-microdegrees during reduction
  localparam int M_W         = 28;  // folded angle magnitude
  localparam int K_W         = 31;
  localparam int Z_W         = 33;  // cordic angle accumulator, q30 radians
  localparam int XY_W        = 34;  // cordic x and y
  localparam int TRIG_W      = 32;  // sin and cos and their products, q30
  localparam int A_W         = 31;  // haversine term, 0 .. 2^30
  localparam int SQ_N_W      = 61;  // radicand a << 30
  localparam int SQ_R_W      = 63;  // root accumulator
  localparam int SQRT_STEPS  = 31;
  localparam int ROOT_W      = 31;
  localparam int RADIUS_W    = 23;
  localparam int DIST_W      = 25;
  localparam int PROD_W      = RADIUS_W + Z_W;
  localparam int LANES       = 4;
  localparam int ADDR_W      = 3;
  localparam int DATA_W      = 32;

  localparam logic [RADIUS_W-1:0] RADIUS_RESET  = 23'd6371000;
  localparam logic [DIST_W-1:0]   DIST_MAX      = 25'd26353589;
  localparam logic [K_W-1:0]      RAD_K         = 31'd1257642267;
  localparam logic signed [XY_W-1:0] INV_GAIN   = 34'sd652032874;
  localparam logic [A_W-1:0]      ONE_Q30       = 31'd1073741824;
  localparam logic signed [RED_W-1:0] FULL_TURN_H    = 31'sd720000000;
  localparam logic signed [RED_W-1:0] HALF_TURN_H    = 31'sd360000000;
  localparam logic signed [RED_W-1:0] QUARTER_TURN_H = 31'sd180000000;

  // word index of the radius register
  localparam logic REG_RADIUS = 1'b0;

  typedef struct packed {
    logic neg;
    logic flip;
  } rot_ctl_t;

  function automatic logic signed [Z_W-1:0] atan_entry(input int i);
    logic signed [Z_W-1:0] v;
    case (i)
      0: v = 33'sd843314856;
      1: v = 33'sd497837829;
      2: v = 33'sd263043836;
      3: v = 33'sd133525158;
      4: v = 33'sd67021686;
      5: v = 33'sd33543515;
      6: v = 33'sd16775850;
      7: v = 33'sd8388437;
      8: v = 33'sd4194282;
      9: v = 33'sd2097149;
      default: begin
        if (i <= 30) v = Z_W'(64'sd1 <<< (30 - i));
        else v = '0;
      end
    endcase
    return v;
  endfunction

endpackage

// ===== design/great_circle_distance_core.sv =====
// haversine great-circle distance between two points given in microdegrees
//
// input channel: in_valid_i / in_stall_o with first_lat_i, first_lon_i,
// second_lat_i, second_lon_i; a word is taken on a clock edge with valid high
// and stall low. output channel: out_valid_o / out_stall_i with distance_m_o,
// in whole metres, rounded to nearest and saturated at 26353589.
// sphere radius is set over the apb port, register 0 at byte address 0;
// write it only while no word is in flight.
// throughput: one word per cycle while the output is not stalled. stages:
// input register, angle fold, radian multiply, CORDIC_STAGES rotation cells,
// sign fix, three product stages, 31 square-root cells, CORDIC_STAGES
// vectoring cells, radius multiply, output register.
// every stage moves on one common enable, which drops only while a result
// sits in the output register and out_stall_i is high; a single skid word at
// the input keeps in_stall_o a plain register.
// reset clears all valid bits, the skid word's included, and loads the earth mean
// radius, 6371000 m; no data is lost while the receiver stalls.
module great_circle_distance_core #(
  parameter int CORDIC_STAGES = 24
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [gcd_pkg::ADDR_W-1:0]     paddr,
  input  logic [gcd_pkg::DATA_W-1:0]     pwdata,
  output logic [gcd_pkg::DATA_W-1:0]     prdata,
  output logic                           pready,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic signed [27:0]             first_lat_i,
  input  logic signed [28:0]             first_lon_i,
  input  logic signed [27:0]             second_lat_i,
  input  logic signed [28:0]             second_lon_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [gcd_pkg::DIST_W-1:0]     distance_m_o
);
  import gcd_pkg::*;

  // ---------------------------------------------------------------- config
  logic [RADIUS_W-1:0] radius_q;
  logic                reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[ADDR_W-1] == REG_RADIUS);
  assign prdata  = reg_sel ? DATA_W'(radius_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RADIUS_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      radius_q <= pwdata[RADIUS_W-1:0];
    end
  end

  // ---------------------------------------------------------------- flow
  logic en;
  logic out_valid_q;
  logic skid_valid_q;
  logic signed [27:0] skid_lat1_q, skid_lat2_q;
  logic signed [28:0] skid_lon1_q, skid_lon2_q;

  assign en         = !(out_valid_q && out_stall_i);
  assign in_stall_o = skid_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q && en) begin
      skid_valid_q <= 1'b0;
    end else if (!skid_valid_q && in_valid_i && !en) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!skid_valid_q && in_valid_i && !en) begin
      skid_lat1_q <= first_lat_i;
      skid_lon1_q <= first_lon_i;
      skid_lat2_q <= second_lat_i;
      skid_lon2_q <= second_lon_i;
    end
  end

  // ---------------------------------------------------------------- input register
  logic               v0_q;
  logic signed [27:0] lat1_q, lat2_q;
  logic signed [28:0] lon1_q, lon2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      lat1_q <= skid_valid_q ? skid_lat1_q : first_lat_i;
      lon1_q <= skid_valid_q ? skid_lon1_q : first_lon_i;
      lat2_q <= skid_valid_q ? skid_lat2_q : second_lat_i;
      lon2_q <= skid_valid_q ? skid_lon2_q : second_lon_i;
    end
  end

  // ---------------------------------------------------------------- angle fold
  // lanes: lat1, lat2, half lat difference, half lon difference (half-microdegrees)
  logic signed [RED_W-1:0] h_raw [LANES];
  logic signed [RED_W-1:0] h_red [LANES];
  logic [M_W-1:0]          m_d   [LANES];
  rot_ctl_t                ctl_d [LANES];
  logic [M_W-1:0]          m_q   [LANES];
  rot_ctl_t                ctl1_q[LANES];

  always_comb begin
    h_raw[0] = RED_W'(lat1_q) <<< 1;
    h_raw[1] = RED_W'(lat2_q) <<< 1;
    h_raw[2] = RED_W'(lat2_q) - RED_W'(lat1_q);
    h_raw[3] = RED_W'(lon2_q) - RED_W'(lon1_q);
    for (int l = 0; l < LANES; l++) begin
      h_red[l] = h_raw[l];
      if (h_red[l] >= HALF_TURN_H) h_red[l] = h_red[l] - FULL_TURN_H;
      else if (h_red[l] < -HALF_TURN_H) h_red[l] = h_red[l] + FULL_TURN_H;
      ctl_d[l].flip = 1'b0;
      if (h_red[l] > QUARTER_TURN_H) begin
        h_red[l] = h_red[l] - HALF_TURN_H;
        ctl_d[l].flip = 1'b1;
      end else if (h_red[l] < -QUARTER_TURN_H) begin
        h_red[l] = h_red[l] + HALF_TURN_H;
        ctl_d[l].flip = 1'b1;
      end
      ctl_d[l].neg = h_red[l][RED_W-1];
      m_d[l] = ctl_d[l].neg ? M_W'(-h_red[l]) : M_W'(h_red[l]);
    end
  end

  logic v1_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_q    <= m_d;
      ctl1_q <= ctl_d;
    end
  end

  // ---------------------------------------------------------------- to radians
  logic signed [Z_W-1:0] z0_q   [LANES];
  rot_ctl_t              ctl2_q [LANES];
  logic [M_W+K_W-1:0]    rad_p  [LANES];
  logic v2_q;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      rad_p[l] = (M_W+K_W)'(m_q[l]) * (M_W+K_W)'(RAD_K) + (M_W+K_W)'(64'd1 << 26);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int l = 0; l < LANES; l++) begin
        z0_q[l] <= Z_W'(rad_p[l] >> 27);
      end
      ctl2_q <= ctl1_q;
    end
  end

  // ---------------------------------------------------------------- rotation cells
  logic signed [XY_W-1:0] rx [CORDIC_STAGES+1][LANES];
  logic signed [XY_W-1:0] ry [CORDIC_STAGES+1][LANES];
  logic signed [Z_W-1:0]  rz [CORDIC_STAGES+1][LANES];
  rot_ctl_t               rc [CORDIC_STAGES+1][LANES];

  for (genvar l = 0; l < LANES; l++) begin : g_seed
    assign rx[0][l] = INV_GAIN;
    assign ry[0][l] = '0;
    assign rz[0][l] = z0_q[l];
    assign rc[0][l] = ctl2_q[l];
  end

  for (genvar s = 0; s < CORDIC_STAGES; s++) begin : g_rot
    for (genvar l = 0; l < LANES; l++) begin : g_lane
      gcd_rot_cell #(.STAGE(s)) u_cell (
        .clk_i (clk_i),
        .en_i  (en),
        .x_i   (rx[s][l]),
        .y_i   (ry[s][l]),
        .z_i   (rz[s][l]),
        .ctl_i (rc[s][l]),
        .x_o   (rx[s+1][l]),
        .y_o   (ry[s+1][l]),
        .z_o   (rz[s+1][l]),
        .ctl_o (rc[s+1][l])
      );
    end
  end

  // ---------------------------------------------------------------- sign fix
  logic signed [TRIG_W-1:0] sin_q [LANES];
  logic signed [TRIG_W-1:0] cos_q [LANES];
  logic v3_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int l = 0; l < LANES; l++) begin
        sin_q[l] <= (rc[CORDIC_STAGES][l].neg ^ rc[CORDIC_STAGES][l].flip)
                    ? TRIG_W'(-ry[CORDIC_STAGES][l]) : TRIG_W'(ry[CORDIC_STAGES][l]);
        cos_q[l] <= rc[CORDIC_STAGES][l].flip
                    ? TRIG_W'(-rx[CORDIC_STAGES][l]) : TRIG_W'(rx[CORDIC_STAGES][l]);
      end
    end
  end

  // ---------------------------------------------------------------- haversine term
  logic signed [2*TRIG_W-1:0] p_sdf, p_sdl, p_cc, p_t;
  logic signed [TRIG_W-1:0]   sdf2_q, sdl2_q, cc_q, sdf2_d1_q, t_q;
  logic signed [TRIG_W:0]     a_sum;
  logic [A_W-1:0]             a_cl;
  logic [SQ_N_W-1:0]          na_q, nb_q;
  logic v4_q, v5_q, v6_q;

  assign p_sdf = sin_q[2] * sin_q[2];
  assign p_sdl = sin_q[3] * sin_q[3];
  assign p_cc  = cos_q[0] * cos_q[1];
  assign p_t   = cc_q * sdl2_q;

  always_comb begin
    a_sum = (TRIG_W+1)'(sdf2_d1_q) + (TRIG_W+1)'(t_q);
    if (a_sum < 0) a_cl = '0;
    else if (a_sum > $signed({2'b00, ONE_Q30})) a_cl = ONE_Q30;
    else a_cl = A_W'(a_sum);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sdf2_q    <= p_sdf[TRIG_W+29:30];
      sdl2_q    <= p_sdl[TRIG_W+29:30];
      cc_q      <= p_cc[TRIG_W+29:30];
      sdf2_d1_q <= sdf2_q;
      t_q       <= p_t[TRIG_W+29:30];
      na_q      <= {a_cl, 30'd0};
      nb_q      <= {A_W'(ONE_Q30 - a_cl), 30'd0};
    end
  end

  // ---------------------------------------------------------------- square-root cells
  logic [SQ_N_W-1:0] qn [2][SQRT_STEPS+1];
  logic [SQ_R_W-1:0] qr [2][SQRT_STEPS+1];

  assign qn[0][0] = na_q;
  assign qn[1][0] = nb_q;
  assign qr[0][0] = '0;
  assign qr[1][0] = '0;

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    for (genvar l = 0; l < 2; l++) begin : g_lane
      gcd_sqrt_cell #(.STEP(k)) u_cell (
        .clk_i (clk_i),
        .en_i  (en),
        .n_i   (qn[l][k]),
        .r_i   (qr[l][k]),
        .n_o   (qn[l][k+1]),
        .r_o   (qr[l][k+1])
      );
    end
  end

  // ---------------------------------------------------------------- vectoring cells
  logic signed [XY_W-1:0] vx [CORDIC_STAGES+1];
  logic signed [XY_W-1:0] vy [CORDIC_STAGES+1];
  logic signed [Z_W-1:0]  vz [CORDIC_STAGES+1];

  assign vx[0] = XY_W'(qr[1][SQRT_STEPS][ROOT_W-1:0]);
  assign vy[0] = XY_W'(qr[0][SQRT_STEPS][ROOT_W-1:0]);
  assign vz[0] = '0;

  for (genvar s = 0; s < CORDIC_STAGES; s++) begin : g_vec
    gcd_vec_cell #(.STAGE(s)) u_cell (
      .clk_i (clk_i),
      .en_i  (en),
      .x_i   (vx[s]),
      .y_i   (vy[s]),
      .z_i   (vz[s]),
      .x_o   (vx[s+1]),
      .y_o   (vy[s+1]),
      .z_o   (vz[s+1])
    );
  end

  // ---------------------------------------------------------------- radius scale
  logic [Z_W-1:0]    c_pos;
  logic [PROD_W-1:0] prod_q;
  logic [PROD_W:0]   rnd;
  logic [PROD_W-30:0] d_full;
  logic [DIST_W-1:0] dist_q;
  logic v7_q;

  assign c_pos  = vz[CORDIC_STAGES][Z_W-1] ? '0 : {vz[CORDIC_STAGES][Z_W-2:0], 1'b0};
  assign rnd    = (PROD_W+1)'(prod_q) + (PROD_W+1)'(64'd1 << 29);
  assign d_full = rnd[PROD_W:30];

  always_ff @(posedge clk_i) begin
    if (en) begin
      prod_q <= PROD_W'(radius_q) * PROD_W'(c_pos);
      dist_q <= (d_full > (PROD_W-29)'(DIST_MAX)) ? DIST_MAX : DIST_W'(d_full);
    end
  end

  // ---------------------------------------------------------------- valid chain
  localparam int VLD_N = CORDIC_STAGES;
  logic [VLD_N-1:0] vchain_q;
  logic [CORDIC_STAGES+SQRT_STEPS-1:0] vtail_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q        <= 1'b0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      v5_q        <= 1'b0;
      v6_q        <= 1'b0;
      v7_q        <= 1'b0;
      vchain_q    <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v0_q     <= skid_valid_q || in_valid_i;
      v1_q     <= v0_q;
      v2_q     <= v1_q;
      vchain_q <= {vchain_q[VLD_N-2:0], v2_q};
      // rotation cells end, then sign fix and products
      v3_q     <= vchain_q[CORDIC_STAGES-1];
      v4_q     <= v3_q;
      v5_q     <= v4_q;
      v6_q     <= v5_q;
      v7_q     <= vtail_q[CORDIC_STAGES+SQRT_STEPS-1];
      out_valid_q <= v7_q;
    end
  end

  // the chain's tail past the rotation cells tracks square-root and vectoring
  // cells; its head is refilled from v6 to keep them aligned
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vtail_q <= '0;
    end else if (en) begin
      vtail_q <= {vtail_q[CORDIC_STAGES+SQRT_STEPS-2:0], v6_q};
    end
  end

  assign out_valid_o  = out_valid_q;
  assign distance_m_o = dist_q;

endmodule

// ===== design/gcd_rot_cell.sv =====
module gcd_rot_cell #(
  parameter int STAGE = 0
) (
  input  logic                             clk_i,
  input  logic                             en_i,
  input  logic signed [gcd_pkg::XY_W-1:0]  x_i,
  input  logic signed [gcd_pkg::XY_W-1:0]  y_i,
  input  logic signed [gcd_pkg::Z_W-1:0]   z_i,
  input  gcd_pkg::rot_ctl_t                ctl_i,
  output logic signed [gcd_pkg::XY_W-1:0]  x_o,
  output logic signed [gcd_pkg::XY_W-1:0]  y_o,
  output logic signed [gcd_pkg::Z_W-1:0]   z_o,
  output gcd_pkg::rot_ctl_t                ctl_o
);
  import gcd_pkg::*;

  logic signed [XY_W-1:0] x_d, y_d, xs, ys;
  logic signed [Z_W-1:0]  z_d;

  // rotation mode: drive the residual angle towards zero
  always_comb begin
    xs = x_i >>> STAGE;
    ys = y_i >>> STAGE;
    if (z_i >= 0) begin
      x_d = x_i - ys;
      y_d = y_i + xs;
      z_d = z_i - atan_entry(STAGE);
    end else begin
      x_d = x_i + ys;
      y_d = y_i - xs;
      z_d = z_i + atan_entry(STAGE);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_o   <= x_d;
      y_o   <= y_d;
      z_o   <= z_d;
      ctl_o <= ctl_i;
    end
  end

endmodule

// ===== design/gcd_sqrt_cell.sv =====
module gcd_sqrt_cell #(
  parameter int STEP = 0
) (
  input  logic                             clk_i,
  input  logic                             en_i,
  input  logic [gcd_pkg::SQ_N_W-1:0]       n_i,
  input  logic [gcd_pkg::SQ_R_W-1:0]       r_i,
  output logic [gcd_pkg::SQ_N_W-1:0]       n_o,
  output logic [gcd_pkg::SQ_R_W-1:0]       r_o
);
  import gcd_pkg::*;

  localparam int BIT_POS = 2 * (SQRT_STEPS - 1 - STEP);

  logic [SQ_R_W-1:0] bit_w, trial, r_d;
  logic [SQ_N_W-1:0] n_d;

  // one root bit per cell
  always_comb begin
    bit_w = SQ_R_W'(1) << BIT_POS;
    trial = r_i + bit_w;
    if (SQ_R_W'(n_i) >= trial) begin
      n_d = SQ_N_W'(SQ_R_W'(n_i) - trial);
      r_d = (r_i >> 1) + bit_w;
    end else begin
      n_d = n_i;
      r_d = r_i >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n_o <= n_d;
      r_o <= r_d;
    end
  end

endmodule

// ===== design/gcd_vec_cell.sv =====
module gcd_vec_cell #(
  parameter int STAGE = 0
) (
  input  logic                             clk_i,
  input  logic                             en_i,
  input  logic signed [gcd_pkg::XY_W-1:0]  x_i,
  input  logic signed [gcd_pkg::XY_W-1:0]  y_i,
  input  logic signed [gcd_pkg::Z_W-1:0]   z_i,
  output logic signed [gcd_pkg::XY_W-1:0]  x_o,
  output logic signed [gcd_pkg::XY_W-1:0]  y_o,
  output logic signed [gcd_pkg::Z_W-1:0]   z_o
);
  import gcd_pkg::*;

  logic signed [XY_W-1:0] x_d, y_d, xs, ys;
  logic signed [Z_W-1:0]  z_d;

  // vectoring mode: drive y towards zero, collect the angle
  always_comb begin
    xs = x_i >>> STAGE;
    ys = y_i >>> STAGE;
    if (y_i >= 0) begin
      x_d = x_i + ys;
      y_d = y_i - xs;
      z_d = z_i + atan_entry(STAGE);
    end else begin
      x_d = x_i - ys;
      y_d = y_i + xs;
      z_d = z_i - atan_entry(STAGE);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_o <= x_d;
      y_o <= y_d;
      z_o <= z_d;
    end
  end

endmodule
